@@ design/bfvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvc_pkg
// Shared types, codes and constants for the body-frame velocity clamp.
// ----------------------------------------------------------------------------
package bfvc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(CORDIC_RUN);
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  localparam int VEL_W  = 16;
  localparam int CAP_W  = 15;
  localparam int CS_W   = 34;              // Q2.30 plus guard bits
  localparam int ZW     = 33;              // residual angle, 2^32 per turn
  localparam int PROD_W = CS_W + VEL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC_SH = 30;
  localparam int RND_W  = ACC_W - FRAC_SH;

  typedef logic signed [CS_W-1:0] cs_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_FIN
  } state_t;

  localparam logic [1:0] FUNC_CMD  = 2'd0;
  localparam logic [1:0] FUNC_HEAD = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] REG_FWD_CAP  = 2'd0;
  localparam logic [1:0] REG_LAT_CAP  = 2'd1;
  localparam logic [1:0] REG_TURN_CAP = 2'd2;

  localparam logic [CAP_W-1:0] FWD_CAP_RST  = 15'd1024;
  localparam logic [CAP_W-1:0] LAT_CAP_RST  = 15'd512;
  localparam logic [CAP_W-1:0] TURN_CAP_RST = 15'd1024;

  // 1/K for the infinite product, Q2.30
  localparam cs_t CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_SH - 1);

  // arctan(2^-i), 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

@@ design/bfvc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvc_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a 16-bit binary angle,
// one micro-rotation per cycle on a shared add/shift datapath.
// ----------------------------------------------------------------------------
module bfvc_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [15:0]   angle,
  output logic          done,
  output bfvc_pkg::cs_t cos_out,
  output bfvc_pkg::cs_t sin_out
);
  import bfvc_pkg::*;

  cs_t                   x_r, y_r, dx, dy;
  logic signed [ZW-1:0]  z_r, da, z_init;
  logic [STEP_W-1:0]     step_r;
  logic                  run_r, done_r, flip_r, flip_in;
  logic [31:0]           z32;

  // quadrants 1 and 2 fold over by half a turn
  assign flip_in = angle[15] ^ angle[14];
  assign z32     = {angle[15] ^ flip_in, angle[14:0], 16'b0};
  assign z_init  = {z32[31], z32};

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign da = {3'b000, atan_turn(ATAN_IDX_W'(step_r))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(CORDIC_RUN - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= z_init;
      flip_r <= flip_in;
    end else if (run_r) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

  assign done    = done_r;
  assign cos_out = flip_r ? -x_r : x_r;
  assign sin_out = flip_r ? -y_r : y_r;

endmodule

@@ design/body_frame_velocity_clamp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_frame_velocity_clamp_core
// Rotates the held world-frame velocity into the body frame and clamps it and the turn rate.
// ----------------------------------------------------------------------------
// Sequence: a command or heading request is registered into the held state;
//   an inactive tick goes through FIN into the output register; an active
//   tick runs 16 CORDIC steps, the done handoff, the multiply phase on one
//   shared 34x16 multiplier, then the clamp/output step in FIN. No new
//   request is taken until the result is loaded; in_tready is low meanwhile.
// Reset (rst_n sync, active low): caps to 1.0/0.5/1.0, held state and flags
//   cleared, output empty.
// ----------------------------------------------------------------------------
module body_frame_velocity_clamp_core (
  input  logic        clk,
  input  logic        rst_n,
  // input request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // vel_x[15:0], vel_y[31:16], yaw_rate[47:32], heading[63:48]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // body_vx[15:0], body_vy[31:16], body_turn[47:32]
  output logic        out_tuser,  // active[0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import bfvc_pkg::*;

  localparam logic [2:0] MUL_LAST = 3'd4;

  state_t state_r, state_nxt;

  // configuration
  logic [CAP_W-1:0] fwd_cap_r, lat_cap_r, turn_cap_r;

  // held command and heading
  logic signed [VEL_W-1:0] held_vx_r, held_vy_r, held_turn_r;
  logic [15:0]             held_heading_r;
  logic                    got_cmd_r, got_head_r, active_r;

  logic in_acc, is_tick, tick_active;

  // CORDIC
  logic cordic_start, cordic_done;
  cs_t  cos_v, sin_v;

  // shared multiplier and accumulators
  logic [2:0]               k_r;
  cs_t                      mul_a;
  logic signed [VEL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  bx_r, by_r, bx_sum, by_sum;
  logic signed [RND_W-1:0]  bx_rnd, by_rnd, turn_ext;

  // output register
  logic        out_tvalid_r, out_tuser_r, out_load;
  logic [47:0] out_tdata_r;
  logic [47:0] res_data;

  function automatic logic [15:0] clamp_cap(input logic signed [RND_W-1:0] v,
                                            input logic [CAP_W-1:0] cap);
    logic signed [RND_W-1:0] c;
    logic signed [RND_W-1:0] r;
    c = $signed({{(RND_W - CAP_W){1'b0}}, cap});
    if (v > c)       r = c;
    else if (v < -c) r = -c;
    else             r = v;
    return r[15:0];
  endfunction

  assign in_acc      = in_tvalid && in_tready;
  assign is_tick     = (in_tuser == FUNC_TICK);
  assign tick_active = got_cmd_r && got_head_r;
  assign out_load    = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);

  // --------------------------------------------------------------------------
  // Sequencer: IDLE takes requests; an active tick runs ROT -> MUL -> FIN,
  // an inactive one goes to FIN. FIN waits only for a free output register,
  // so command and heading requests are taken while a result sits unread.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cordic_start = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && is_tick) begin
          if (tick_active) begin
            cordic_start = 1'b1;
            state_nxt    = ST_ROT;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ROT: begin
        if (cordic_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (k_r == MUL_LAST) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Config and held state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_cap_r      <= FWD_CAP_RST;
      lat_cap_r      <= LAT_CAP_RST;
      turn_cap_r     <= TURN_CAP_RST;
      held_vx_r      <= '0;
      held_vy_r      <= '0;
      held_turn_r    <= '0;
      held_heading_r <= '0;
      got_cmd_r      <= 1'b0;
      got_head_r     <= 1'b0;
      active_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FWD_CAP:  fwd_cap_r  <= cfg_wdata;
          REG_LAT_CAP:  lat_cap_r  <= cfg_wdata;
          REG_TURN_CAP: turn_cap_r <= cfg_wdata;
          default: ;  // unmapped index: write dropped
        endcase
      end
      if (in_acc) begin
        unique case (in_tuser)
          FUNC_CMD: begin
            held_vx_r   <= in_tdata[15:0];
            held_vy_r   <= in_tdata[31:16];
            held_turn_r <= in_tdata[47:32];
            got_cmd_r   <= 1'b1;
          end
          FUNC_HEAD: begin
            held_heading_r <= in_tdata[63:48];
            got_head_r     <= 1'b1;
          end
          FUNC_TICK: active_r <= tick_active;
          default: ;  // unknown kind: taken and dropped
        endcase
      end
    end
  end

  bfvc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (held_heading_r),
    .done    (cordic_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  // --------------------------------------------------------------------------
  // Multiply phase, one product per cycle, registered and accumulated in the cycle after:
  //   bx = c*vx + s*vy,  by = c*vy - s*vx   (Q7.40)
  // --------------------------------------------------------------------------
  always_comb begin
    case (k_r)
      3'd0:    begin mul_a = cos_v; mul_b = held_vx_r; end
      3'd1:    begin mul_a = sin_v; mul_b = held_vy_r; end
      3'd2:    begin mul_a = cos_v; mul_b = held_vy_r; end
      default: begin mul_a = sin_v; mul_b = held_vx_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (state_r == ST_MUL) begin
      k_r <= k_r + 3'd1;
    end else begin
      k_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
      case (k_r)
        3'd1:    bx_r <= ACC_W'(prod_r);
        3'd2:    bx_r <= bx_r + ACC_W'(prod_r);
        3'd3:    by_r <= ACC_W'(prod_r);
        3'd4:    by_r <= by_r - ACC_W'(prod_r);
        default: ;
      endcase
    end
  end

  // round to Q5.10 (add half, floor shift), then clamp symmetrically
  assign bx_sum   = bx_r + RND_HALF;
  assign by_sum   = by_r + RND_HALF;
  assign bx_rnd   = RND_W'(bx_sum >>> FRAC_SH);
  assign by_rnd   = RND_W'(by_sum >>> FRAC_SH);
  assign turn_ext = RND_W'(held_turn_r);

  assign res_data = {clamp_cap(turn_ext, turn_cap_r),
                     clamp_cap(by_rnd, lat_cap_r),
                     clamp_cap(bx_rnd, fwd_cap_r)};

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tuser_r <= active_r;
      out_tdata_r <= active_r ? res_data : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == ST_ROT))
    else $error("CORDIC finished outside rotation phase");

  a_active_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick && tick_active) |=> (state_r == ST_ROT))
    else $error("active tick did not start rotation");

  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 48'd0))
    else $error("inactive result carries nonzero data");

  a_fwd_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ($signed(out_tdata[15:0]) <= $signed({1'b0, fwd_cap_r}) &&
       $signed(out_tdata[15:0]) >= -$signed({1'b0, fwd_cap_r})))
    else $error("forward speed outside cap");

endmodule
